FILE: rtl/core/wlc_pkg.sv
// shared types and codes for the mirrored wear level usage counter
// used by wlc_scan and the core module; depends on nothing
`timescale 1ns / 1ps

package wlc_pkg;

	localparam int TOTAL_W   = 32;
	localparam int MINUTES_W = 16;
	localparam int SLOT_OUT_W = 8;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_ADD    = 2'd1,
		OP_RESCAN = 2'd2,
		OP_SPARE  = 2'd3
	} wlc_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_WR,
		S_SCAN,
		S_SCAN_END,
		S_SCAN_OUT
	} wlc_state_t;

	// control from the sequencer to the rescan tracker
	typedef struct packed {
		logic clear;
		logic sample;
		logic p_ok;
		logic b_ok;
	} wlc_scan_ctl_t;

endpackage

FILE: rtl/core/wlc_ram.sv
// simple dual port record memory: one write and one registered read per cycle
// depends on nothing
`timescale 1ns / 1ps

module wlc_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/wlc_scan.sv
// rescan tracker: running maximum of valid primary and backup records
// depends on wlc_pkg
`timescale 1ns / 1ps

module wlc_scan #(
	parameter int SLOT_W = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wlc_pkg::wlc_scan_ctl_t         ctl,
	input  logic [SLOT_W-1:0]              idx,
	input  logic [wlc_pkg::TOTAL_W-1:0]    p_data,
	input  logic [wlc_pkg::TOTAL_W-1:0]    b_data,
	output logic [SLOT_W-1:0]              best_slot
);

	logic [wlc_pkg::TOTAL_W-1:0] pmax_q, bmax_q;
	logic [SLOT_W-1:0]           pslot_q, bslot_q;

	// strict compare keeps the earliest slot on ties and ignores zero values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmax_q  <= '0;
			bmax_q  <= '0;
			pslot_q <= '0;
			bslot_q <= '0;
		end else if (ctl.clear) begin
			pmax_q  <= '0;
			bmax_q  <= '0;
			pslot_q <= '0;
			bslot_q <= '0;
		end else if (ctl.sample) begin
			if (ctl.p_ok && (p_data > pmax_q)) begin
				pmax_q  <= p_data;
				pslot_q <= idx;
			end
			if (ctl.b_ok && (b_data > bmax_q)) begin
				bmax_q  <= b_data;
				bslot_q <= idx;
			end
		end
	end

	// with nothing found both slots stay zero
	assign best_slot = (bmax_q > pmax_q) ? bslot_q : pslot_q;

endmodule

FILE: rtl/core/mirrored_wear_level_usage_counter_core.sv
// top level of the mirrored wear level usage counter: sequencer, page intervals
// depends on wlc_pkg, wlc_ram, wlc_scan
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+----------------------------
//  input   | in_valid / in_stall  | opcode[1:0], minutes[15:0]
//  output  | out_valid / out_stall| total[31:0], slot[7:0]
//
//  read: memory read, then select into the output register
//  add: memory read, repair write, new record write
//  rescan: one slot per cycle through the memory read port
//  in_stall is high while one word is in flight; a finished word waits in the
//  output register, and the next word's final step holds until it is taken
//  reset clears the slot pointer and both page intervals; no clearing pass

module mirrored_wear_level_usage_counter_core #(
	parameter int RECORD_SLOTS = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic [wlc_pkg::MINUTES_W-1:0]      minutes,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [wlc_pkg::TOTAL_W-1:0]        total,
	output logic [wlc_pkg::SLOT_OUT_W-1:0]     slot
);

	localparam int SLOT_W = $clog2(RECORD_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RECORD_SLOTS - 1);

	// each page's valid flags always form one interval [lo, hi]: records are
	// written only at the current slot or the one after it, and a page is
	// erased before a record lands outside its interval
	logic              p_ne_q, b_ne_q;
	logic [SLOT_W-1:0] p_lo_q, p_hi_q, b_lo_q, b_hi_q;

	wlc_pkg::wlc_state_t state_q, state_d;
	wlc_pkg::wlc_op_t    op_q;
	logic [wlc_pkg::MINUTES_W-1:0] minutes_q;
	logic [SLOT_W-1:0]   cur_slot_q;
	logic [SLOT_W-1:0]   scan_idx_q;
	logic [SLOT_W-1:0]   idx_s1;
	logic                scan_v_s1;
	logic [wlc_pkg::TOTAL_W-1:0] base_q;

	logic                out_valid_q;
	logic [wlc_pkg::TOTAL_W-1:0]    total_q;
	logic [wlc_pkg::SLOT_OUT_W-1:0] slot_q;

	// memory ports
	logic [SLOT_W-1:0]           rd_addr;
	logic                        p_we, b_we;
	logic [SLOT_W-1:0]           p_wr_addr, b_wr_addr;
	logic [wlc_pkg::TOTAL_W-1:0] p_wr_data, b_wr_data;
	logic [wlc_pkg::TOTAL_W-1:0] p_rd_data, b_rd_data;

	wlc_pkg::wlc_scan_ctl_t scan_ctl;
	logic [SLOT_W-1:0]      best_slot;

	logic                        accept, out_free, pv, bv, wrap;
	logic [SLOT_W-1:0]           nxt_slot;
	logic [wlc_pkg::TOTAL_W-1:0] sum;
	logic                        out_load;
	logic [wlc_pkg::TOTAL_W-1:0] out_total;
	logic [SLOT_W-1:0]           out_slot;

	function automatic logic in_range(logic ne, logic [SLOT_W-1:0] lo,
			logic [SLOT_W-1:0] hi, logic [SLOT_W-1:0] i);
		return ne && (i >= lo) && (i <= hi);
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != wlc_pkg::S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// flags of the current slot, used by read and add
	assign pv       = in_range(p_ne_q, p_lo_q, p_hi_q, cur_slot_q);
	assign bv       = in_range(b_ne_q, b_lo_q, b_hi_q, cur_slot_q);
	assign wrap     = (cur_slot_q == LAST_SLOT);
	assign nxt_slot = wrap ? '0 : cur_slot_q + SLOT_W'(1);
	assign sum      = base_q + wlc_pkg::TOTAL_W'(minutes_q);

	wlc_ram #(.DEPTH(RECORD_SLOTS), .WIDTH(wlc_pkg::TOTAL_W)) u_primary (
		.clk     (clk),
		.we      (p_we),
		.wr_addr (p_wr_addr),
		.wr_data (p_wr_data),
		.rd_addr (rd_addr),
		.rd_data (p_rd_data)
	);

	wlc_ram #(.DEPTH(RECORD_SLOTS), .WIDTH(wlc_pkg::TOTAL_W)) u_backup (
		.clk     (clk),
		.we      (b_we),
		.wr_addr (b_wr_addr),
		.wr_data (b_wr_data),
		.rd_addr (rd_addr),
		.rd_data (b_rd_data)
	);

	wlc_scan #(.SLOT_W(SLOT_W)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.idx       (idx_s1),
		.p_data    (p_rd_data),
		.b_data    (b_rd_data),
		.best_slot (best_slot)
	);

	// scan samples take the flags of the slot whose data just came back
	always_comb begin
		scan_ctl.clear  = accept && (wlc_pkg::wlc_op_t'(opcode) == wlc_pkg::OP_RESCAN);
		scan_ctl.sample = scan_v_s1;
		scan_ctl.p_ok   = in_range(p_ne_q, p_lo_q, p_hi_q, idx_s1);
		scan_ctl.b_ok   = in_range(b_ne_q, b_lo_q, b_hi_q, idx_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wlc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory controls and output load
	always_comb begin
		state_d   = state_q;
		rd_addr   = cur_slot_q;
		p_we      = 1'b0;
		b_we      = 1'b0;
		p_wr_addr = cur_slot_q;
		b_wr_addr = cur_slot_q;
		p_wr_data = '0;
		b_wr_data = '0;
		out_load  = 1'b0;
		out_total = '0;
		out_slot  = cur_slot_q;
		unique case (state_q)
			wlc_pkg::S_IDLE: begin
				// the read at the current slot is issued here
				if (accept) begin
					if (wlc_pkg::wlc_op_t'(opcode) == wlc_pkg::OP_RESCAN) begin
						state_d = wlc_pkg::S_SCAN;
					end else begin
						state_d = wlc_pkg::S_EVAL;
					end
				end
			end
			wlc_pkg::S_EVAL: begin
				if (op_q == wlc_pkg::OP_ADD) begin
					// repair the missing copy from its mirror, or zero both
					p_we      = !pv;
					p_wr_data = bv ? b_rd_data : '0;
					b_we      = !bv;
					b_wr_data = pv ? p_rd_data : '0;
					state_d   = wlc_pkg::S_WR;
				end else if (out_free) begin
					out_load  = 1'b1;
					out_total = pv ? p_rd_data : (bv ? b_rd_data : '0);
					state_d   = wlc_pkg::S_IDLE;
				end
			end
			wlc_pkg::S_WR: begin
				if (out_free) begin
					p_we      = 1'b1;
					b_we      = 1'b1;
					p_wr_addr = nxt_slot;
					b_wr_addr = nxt_slot;
					p_wr_data = sum;
					b_wr_data = sum;
					out_load  = 1'b1;
					out_total = sum;
					out_slot  = nxt_slot;
					state_d   = wlc_pkg::S_IDLE;
				end
			end
			wlc_pkg::S_SCAN: begin
				rd_addr = scan_idx_q;
				if (scan_idx_q == LAST_SLOT) begin
					state_d = wlc_pkg::S_SCAN_END;
				end
			end
			wlc_pkg::S_SCAN_END: begin
				// last slot's data is sampled at the end of this cycle
				state_d = wlc_pkg::S_SCAN_OUT;
			end
			wlc_pkg::S_SCAN_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_slot = best_slot;
					state_d  = wlc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = wlc_pkg::S_IDLE;
			end
		endcase
	end

	// word registers and the scan pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= wlc_pkg::wlc_op_t'(opcode);
			minutes_q <= minutes;
		end
		if (state_q == wlc_pkg::S_EVAL) begin
			base_q <= pv ? p_rd_data : (bv ? b_rd_data : '0);
		end
		idx_s1 <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1  <= 1'b0;
			scan_idx_q <= '0;
		end else begin
			scan_v_s1 <= (state_q == wlc_pkg::S_SCAN);
			if (accept) begin
				scan_idx_q <= '0;
			end else if (state_q == wlc_pkg::S_SCAN) begin
				scan_idx_q <= scan_idx_q + SLOT_W'(1);
			end
		end
	end

	// slot pointer and page intervals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_slot_q <= '0;
			p_ne_q     <= 1'b0;
			b_ne_q     <= 1'b0;
			p_lo_q     <= '0;
			p_hi_q     <= '0;
			b_lo_q     <= '0;
			b_hi_q     <= '0;
		end else begin
			if (state_q == wlc_pkg::S_EVAL && op_q == wlc_pkg::OP_ADD) begin
				// a repaired copy lands in a freshly erased page
				if (!pv) begin
					p_ne_q <= 1'b1;
					p_lo_q <= cur_slot_q;
					p_hi_q <= cur_slot_q;
				end
				if (!bv) begin
					b_ne_q <= 1'b1;
					b_lo_q <= cur_slot_q;
					b_hi_q <= cur_slot_q;
				end
			end
			if (state_q == wlc_pkg::S_WR && out_free) begin
				cur_slot_q <= nxt_slot;
				if (wrap) begin
					// end of the log: both pages erased, restart at slot zero
					p_lo_q <= '0;
					p_hi_q <= '0;
					b_lo_q <= '0;
					b_hi_q <= '0;
				end else begin
					if (p_hi_q == cur_slot_q) begin
						p_hi_q <= nxt_slot;
					end
					if (b_hi_q == cur_slot_q) begin
						b_hi_q <= nxt_slot;
					end
				end
			end
			if (state_q == wlc_pkg::S_SCAN_OUT && out_free) begin
				cur_slot_q <= best_slot;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			total_q <= out_total;
			slot_q  <= wlc_pkg::SLOT_OUT_W'(out_slot);
		end
	end

	assign out_valid = out_valid_q;
	assign total     = total_q;
	assign slot      = slot_q;

endmodule

FILE: rtl/core/wlc_checker.sv
// port level checks of the usage counter core, with the bind that attaches them
// depends on mirrored_wear_level_usage_counter_core
`timescale 1ns / 1ps

module wlc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  opcode,
	input logic [15:0] minutes,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] total,
	input logic [7:0]  slot
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(total) && $stable(slot))
		else $error("stalled result word changed");

	// one word in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// no result in the cycle right after an accept
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result word too early");

	// a new result word frees the input side
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input still stalled when result appeared");

endmodule

bind mirrored_wear_level_usage_counter_core wlc_checker u_wlc_checker (.*);
